/* rtl/core/rcm_pkg.sv */
// Shared types, constants and frame formatting for the RC pulse to motor command block.
package rcm_pkg;

    localparam int PULSE_BITS_DEF = 22;
    localparam int FIELD_BITS     = 22;

    localparam int CENTER_WIDTH   = 1500;
    localparam int UPPER_BASE     = 1496;
    localparam int SPEED_DEADBAND = 5;
    localparam int TURN_SHIFT     = 3;
    localparam int MAX_SHOWN      = 999;
    localparam int FRAME_LEN      = 14;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    // Byte positions inside one frame.
    localparam logic [3:0] POS_BANG     = 4'd0;
    localparam logic [3:0] POS_M        = 4'd1;
    localparam logic [3:0] POS_GAP0     = 4'd2;
    localparam logic [3:0] POS_SPD_SIGN = 4'd3;
    localparam logic [3:0] POS_SPD_HUN  = 4'd4;
    localparam logic [3:0] POS_SPD_TEN  = 4'd5;
    localparam logic [3:0] POS_SPD_ONE  = 4'd6;
    localparam logic [3:0] POS_GAP1     = 4'd7;
    localparam logic [3:0] POS_TRN_SIGN = 4'd8;
    localparam logic [3:0] POS_TRN_HUN  = 4'd9;
    localparam logic [3:0] POS_TRN_TEN  = 4'd10;
    localparam logic [3:0] POS_TRN_ONE  = 4'd11;
    localparam logic [3:0] POS_CR       = 4'd12;
    localparam logic [3:0] POS_LF       = 4'd13;

    typedef struct packed {
        logic                  speed_capture_valid;
        logic [FIELD_BITS-1:0] speed_pulse_width;
        logic                  turn_capture_valid;
        logic [FIELD_BITS-1:0] turn_pulse_width;
    } pulse_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } frame_out_t;

    typedef struct packed {
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } digits_t;

    // One classified command, waiting in the queue to be serialized.
    typedef struct packed {
        logic    spd_neg;
        digits_t spd;
        logic    trn_neg;
        digits_t trn;
    } cmd_t;

    function automatic logic [7:0] sign_char(input logic neg);
        return neg ? CH_MINUS : CH_SPACE;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return {CH_DIGIT_HI, d};
    endfunction

endpackage

/* rtl/core/rcm_bcd.sv */
// Pipelined binary to three-digit decimal converter for values up to 999.
module rcm_bcd
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [9:0]            value,
    output rcm_pkg::digits_t      digits
);

    logic [9:0] a_val_reg;
    logic [3:0] a_hun_reg;
    logic [3:0] b_hun_reg;
    logic [6:0] b_rem_reg;
    logic [3:0] c_hun_reg;
    logic [6:0] c_rem_reg;
    logic [3:0] c_ten_reg;
    logic [3:0] d_hun_reg;
    logic [3:0] d_ten_reg;
    logic [3:0] d_one_reg;

    logic [15:0] hun_prod;
    logic [9:0]  hun_back;
    logic [14:0] ten_prod;
    logic [6:0]  ten_back;

    // Multiplying by 41/4096 gives the exact quotient by 100 below 1000.
    assign hun_prod = 16'(value) * 16'd41;
    assign hun_back = 10'(a_hun_reg) * 10'd100;
    // Multiplying by 205/2048 gives the exact quotient by 10 below 100.
    assign ten_prod = 15'(b_rem_reg) * 15'd205;
    assign ten_back = 7'(c_ten_reg) * 7'd10;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_val_reg <= value;
            a_hun_reg <= hun_prod[15:12];
            b_hun_reg <= a_hun_reg;
            b_rem_reg <= 7'(a_val_reg - hun_back);
            c_hun_reg <= b_hun_reg;
            c_rem_reg <= b_rem_reg;
            c_ten_reg <= ten_prod[14:11];
            d_hun_reg <= c_hun_reg;
            d_ten_reg <= c_ten_reg;
            d_one_reg <= 4'(c_rem_reg - ten_back);
        end
    end

    assign digits.hun = d_hun_reg;
    assign digits.ten = d_ten_reg;
    assign digits.one = d_one_reg;

endmodule

/* rtl/core/rcm_front.sv */
// Front part: captures pulse widths, derives speed and turn, converts them to digits.
module rcm_front
#(
    parameter int PULSE_BITS = rcm_pkg::PULSE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rcm_pkg::pulse_in_t in_data,
    input  logic               q_full,
    output logic               q_push,
    output rcm_pkg::cmd_t      q_data
);

    // Capture, magnitude, clamp, then four converter stages.
    localparam int NSTAGE = 7;
    localparam int NSIGN  = NSTAGE - 1;

    logic                  advance;
    logic                  accept;
    logic [NSTAGE-1:0]     vld_reg;
    logic [PULSE_BITS-1:0] held_spd_reg;
    logic [PULSE_BITS-1:0] held_trn_reg;
    logic [PULSE_BITS-1:0] spd_mag_reg;
    logic [PULSE_BITS-1:0] trn_mag_reg;
    logic [PULSE_BITS-1:0] trn_shift;
    logic [9:0]            spd_val_reg;
    logic [9:0]            trn_val_reg;
    logic [9:0]            spd_val_next;
    logic [9:0]            trn_val_next;
    logic [NSIGN-1:0]      spd_neg_reg;
    logic [NSIGN-1:0]      trn_neg_reg;
    logic                  spd_hi;
    logic                  trn_hi;
    rcm_pkg::digits_t      spd_digits;
    rcm_pkg::digits_t      trn_digits;

    assign advance  = !q_full;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;
    assign q_push   = vld_reg[NSTAGE-1] && advance;

    assign spd_hi = held_spd_reg >= PULSE_BITS'(rcm_pkg::CENTER_WIDTH);
    assign trn_hi = held_trn_reg >= PULSE_BITS'(rcm_pkg::CENTER_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            held_spd_reg <= '0;
            held_trn_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
            if (in_valid && in_data.speed_capture_valid)
            begin
                held_spd_reg <= PULSE_BITS'(in_data.speed_pulse_width);
            end
            if (accept && in_data.turn_capture_valid)
            begin
                held_trn_reg <= PULSE_BITS'(in_data.turn_pulse_width);
            end
        end
    end

    // Speed drops a small deadband, turn is scaled down by eight; both stop at 999.
    assign trn_shift = trn_mag_reg >> rcm_pkg::TURN_SHIFT;

    always_comb
    begin
        priority if (spd_mag_reg > PULSE_BITS'(rcm_pkg::MAX_SHOWN + rcm_pkg::SPEED_DEADBAND))
        begin
            spd_val_next = 10'(rcm_pkg::MAX_SHOWN);
        end
        else if (spd_mag_reg > PULSE_BITS'(rcm_pkg::SPEED_DEADBAND))
        begin
            spd_val_next = 10'(spd_mag_reg - PULSE_BITS'(rcm_pkg::SPEED_DEADBAND));
        end
        else
        begin
            spd_val_next = '0;
        end

        if (trn_shift > PULSE_BITS'(rcm_pkg::MAX_SHOWN))
        begin
            trn_val_next = 10'(rcm_pkg::MAX_SHOWN);
        end
        else
        begin
            trn_val_next = 10'(trn_shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            spd_mag_reg <= spd_hi ? (held_spd_reg - PULSE_BITS'(rcm_pkg::UPPER_BASE))
                                  : (PULSE_BITS'(rcm_pkg::CENTER_WIDTH) - held_spd_reg);
            trn_mag_reg <= trn_hi ? (held_trn_reg - PULSE_BITS'(rcm_pkg::UPPER_BASE))
                                  : (PULSE_BITS'(rcm_pkg::CENTER_WIDTH) - held_trn_reg);
            spd_val_reg <= spd_val_next;
            trn_val_reg <= trn_val_next;
            spd_neg_reg <= {spd_neg_reg[NSIGN-2:0], spd_hi};
            trn_neg_reg <= {trn_neg_reg[NSIGN-2:0], !trn_hi};
        end
    end

    rcm_bcd u_spd_bcd
    (
        .clk    (clk),
        .en     (advance),
        .value  (spd_val_reg),
        .digits (spd_digits)
    );

    rcm_bcd u_trn_bcd
    (
        .clk    (clk),
        .en     (advance),
        .value  (trn_val_reg),
        .digits (trn_digits)
    );

    assign q_data.spd_neg = spd_neg_reg[NSIGN-1];
    assign q_data.spd     = spd_digits;
    assign q_data.trn_neg = trn_neg_reg[NSIGN-1];
    assign q_data.trn     = trn_digits;

endmodule

/* rtl/core/rcm_queue.sv */
// Two-entry queue of classified commands between the front and back parts.
module rcm_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rcm_pkg::cmd_t push_data,
    input  logic          pop,
    output rcm_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);

    rcm_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/rcm_back.sv */
// Back part: serializes one command into the fourteen bytes of a frame.
module rcm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  rcm_pkg::cmd_t       q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output rcm_pkg::frame_out_t out_data
);

    logic          active_reg;
    logic [3:0]    idx_reg;
    rcm_pkg::cmd_t cur_reg;
    logic          last;
    logic          done;
    logic [7:0]    byte_sel;

    assign last      = idx_reg == rcm_pkg::POS_LF;
    assign done      = active_reg && !out_stall && last;
    assign q_pop     = !q_empty && (!active_reg || done);
    assign out_valid = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= rcm_pkg::POS_BANG;
        end
        else if (q_pop)
        begin
            active_reg <= 1'b1;
            idx_reg    <= rcm_pkg::POS_BANG;
        end
        else if (done)
        begin
            active_reg <= 1'b0;
            idx_reg    <= rcm_pkg::POS_BANG;
        end
        else if (active_reg && !out_stall)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_comb
    begin
        unique case (idx_reg)
            rcm_pkg::POS_BANG:     byte_sel = rcm_pkg::CH_BANG;
            rcm_pkg::POS_M:        byte_sel = rcm_pkg::CH_M;
            rcm_pkg::POS_SPD_SIGN: byte_sel = rcm_pkg::sign_char(cur_reg.spd_neg);
            rcm_pkg::POS_SPD_HUN:  byte_sel = rcm_pkg::digit_char(cur_reg.spd.hun);
            rcm_pkg::POS_SPD_TEN:  byte_sel = rcm_pkg::digit_char(cur_reg.spd.ten);
            rcm_pkg::POS_SPD_ONE:  byte_sel = rcm_pkg::digit_char(cur_reg.spd.one);
            rcm_pkg::POS_TRN_SIGN: byte_sel = rcm_pkg::sign_char(cur_reg.trn_neg);
            rcm_pkg::POS_TRN_HUN:  byte_sel = rcm_pkg::digit_char(cur_reg.trn.hun);
            rcm_pkg::POS_TRN_TEN:  byte_sel = rcm_pkg::digit_char(cur_reg.trn.ten);
            rcm_pkg::POS_TRN_ONE:  byte_sel = rcm_pkg::digit_char(cur_reg.trn.one);
            rcm_pkg::POS_CR:       byte_sel = rcm_pkg::CH_CR;
            rcm_pkg::POS_LF:       byte_sel = rcm_pkg::CH_LF;
            default:               byte_sel = rcm_pkg::CH_SPACE;
        endcase
    end

    assign out_data.frame_byte = byte_sel;
    assign out_data.frame_last = last;

endmodule

/* rtl/core/rc_pulse_to_motor_command.sv */
// Top level of the RC pulse width to motor command frame generator.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall  | pulse_in_t: capture flags, widths
//  out     | output    | out_valid/out_stall| frame_out_t: one frame byte, last
//
// Every accepted item produces one frame of 14 bytes, one byte per cycle while the
// output is not stalled; the byte serializer sets the sustained rate.
// An item passes through the registered front pipeline and then the queue before
// its first byte shows.
// Reset clears the held widths to zero, the pipeline, the queue and the serializer.
// A stalled output freezes the current byte; the front keeps taking items until the
// two-entry queue is full, and then stalls the input.
module rc_pulse_to_motor_command
#(
    parameter int PULSE_BITS = rcm_pkg::PULSE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rcm_pkg::pulse_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rcm_pkg::frame_out_t out_data
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    rcm_pkg::cmd_t q_wdata;
    rcm_pkg::cmd_t q_rdata;

    rcm_front #(.PULSE_BITS(PULSE_BITS)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    rcm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    rcm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* rtl/core/rcm_checker.sv */
// Port-level checks on the motor command frame output, bound to the top level.
module rcm_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input rcm_pkg::frame_out_t out_data
);

    // A stalled byte stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

    // A stalled byte does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
    else $error("output payload changed while stalled");

    // The last byte of a frame is always the line feed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_last |-> out_data.frame_byte == rcm_pkg::CH_LF)
    else $error("frame end marked on a byte other than line feed");

    // Inside a frame the bytes follow one another without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.frame_last |=> out_valid)
    else $error("gap inside a frame");

endmodule

bind rc_pulse_to_motor_command rcm_checker u_rcm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* dv/motor_frame_checker.sv */
// Checker that predicts and compares the motor command frame bytes of the block.
`timescale 1ns / 1ps

module motor_frame_checker
    import rcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  pulse_in_t  in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  frame_out_t out_data,
    output int         fail_count,
    output int         pending
);

    localparam int DIGIT_ZERO = 48;

    logic [FIELD_BITS-1:0] held_speed_width;
    logic [FIELD_BITS-1:0] held_turn_width;
    frame_out_t            expected_frame_bytes[$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Distance from center; widths at or above center measure from the upper base.
    function automatic int width_deviation(input logic [FIELD_BITS-1:0] w);
        if (w >= CENTER_WIDTH)
            return int'(w) - UPPER_BASE;
        return CENTER_WIDTH - int'(w);
    endfunction

    function automatic int speed_magnitude(input logic [FIELD_BITS-1:0] w);
        int dev;
        dev = width_deviation(w);
        dev = (dev > SPEED_DEADBAND) ? dev - SPEED_DEADBAND : 0;
        return (dev > MAX_SHOWN) ? MAX_SHOWN : dev;
    endfunction

    function automatic int turn_magnitude(input logic [FIELD_BITS-1:0] w);
        int dev;
        dev = width_deviation(w) >> TURN_SHIFT;
        return (dev > MAX_SHOWN) ? MAX_SHOWN : dev;
    endfunction

    task automatic queue_motor_frame(input pulse_in_t item);
        logic [7:0] frame_bytes [FRAME_LEN];
        int         spd;
        int         trn;
        frame_out_t entry;
        if (item.speed_capture_valid)
            held_speed_width = item.speed_pulse_width;
        if (item.turn_capture_valid)
            held_turn_width = item.turn_pulse_width;
        spd = speed_magnitude(held_speed_width);
        trn = turn_magnitude(held_turn_width);
        frame_bytes[POS_BANG]     = CH_BANG;
        frame_bytes[POS_M]        = CH_M;
        frame_bytes[POS_GAP0]     = CH_SPACE;
        frame_bytes[POS_SPD_SIGN] = (held_speed_width >= CENTER_WIDTH) ? CH_MINUS : CH_SPACE;
        frame_bytes[POS_SPD_HUN]  = 8'(DIGIT_ZERO + (spd / 100) % 10);
        frame_bytes[POS_SPD_TEN]  = 8'(DIGIT_ZERO + (spd / 10) % 10);
        frame_bytes[POS_SPD_ONE]  = 8'(DIGIT_ZERO + spd % 10);
        frame_bytes[POS_GAP1]     = CH_SPACE;
        frame_bytes[POS_TRN_SIGN] = (held_turn_width < CENTER_WIDTH) ? CH_MINUS : CH_SPACE;
        frame_bytes[POS_TRN_HUN]  = 8'(DIGIT_ZERO + (trn / 100) % 10);
        frame_bytes[POS_TRN_TEN]  = 8'(DIGIT_ZERO + (trn / 10) % 10);
        frame_bytes[POS_TRN_ONE]  = 8'(DIGIT_ZERO + trn % 10);
        frame_bytes[POS_CR]       = CH_CR;
        frame_bytes[POS_LF]       = CH_LF;
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            entry.frame_byte = frame_bytes[k];
            entry.frame_last = (k == FRAME_LEN - 1);
            expected_frame_bytes.push_back(entry);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_out_t want;
        if (!rst_n)
        begin
            held_speed_width = '0;
            held_turn_width  = '0;
            expected_frame_bytes.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            // Outputs are compared first; a frame never shows in the cycle its item enters.
            if (out_valid && !out_stall)
            begin
                if (expected_frame_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("byte 0x%02h transfer with no frame expected",
                                              out_data.frame_byte));
                end
                else
                begin
                    want = expected_frame_bytes.pop_front();
                    if (out_data.frame_byte !== want.frame_byte)
                        report_mismatch($sformatf("frame_byte 0x%02h, expected 0x%02h",
                                                  out_data.frame_byte, want.frame_byte));
                    if (out_data.frame_last !== want.frame_last)
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  out_data.frame_last, want.frame_last));
                end
            end
            if (in_valid && !in_stall)
                queue_motor_frame(in_data);
            pending <= expected_frame_bytes.size();
        end
    end

endmodule

/* dv/rc_pulse_to_motor_command_test.sv */
// Testbench top for the RC pulse to motor command block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module rc_pulse_to_motor_command_test;
    import rcm_pkg::*;

    localparam int RANDOM_PER_PHASE = 36;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    pulse_in_t  in_data;
    logic       out_valid;
    logic       out_stall;
    frame_out_t out_data;
    int         fail_count;
    int         pending;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_request;

    rc_pulse_to_motor_command u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    motor_frame_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // Most widths sit in the usual servo range; some cover every bit of the field.
    function automatic int unsigned random_width();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1510, 1488);
            2: return $urandom_range(9600, 0);
            3: return $urandom_range(9500, 9480);
            default: return $urandom_range(2600, 400);
        endcase
    endfunction

    task automatic send_pulses(input bit sv, input int unsigned sw,
                               input bit tv, input int unsigned tw);
        pulse_in_t item;
        item.speed_capture_valid = sv;
        item.speed_pulse_width   = FIELD_BITS'(sw);
        item.turn_capture_valid  = tv;
        item.turn_pulse_width    = FIELD_BITS'(tw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_items();
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_pulses($urandom_range(3) != 0, random_width(),
                        $urandom_range(3) != 0, random_width());
    endtask

    // The sender waits here until every frame byte has come out.
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        hold_request  = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 72;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing captured yet, then the deadband and center edges.
        send_pulses(1'b0, 0, 1'b0, 0);
        send_pulses(1'b1, 1496, 1'b1, 1500);
        send_pulses(1'b1, 1497, 1'b1, 1499);
        send_pulses(1'b1, 1499, 1'b1, 1503);
        send_pulses(1'b1, 1500, 1'b1, 1504);
        send_pulses(1'b1, 1501, 1'b1, 1507);
        send_pulses(1'b1, 1505, 1'b1, 1511);
        send_pulses(1'b1, 1506, 1'b1, 1492);
        send_pulses(1'b1, 1495, 1'b1, 1493);
        send_pulses(1'b1, 1494, 1'b1, 0);
        send_pulses(1'b1, 1489, 1'b1, 9488);
        // Saturation at 999 on both sides of center.
        send_pulses(1'b1, 2495, 1'b1, 9495);
        send_pulses(1'b1, 2500, 1'b1, 9496);
        send_pulses(1'b1, 2501, 1'b1, 4194303);
        send_pulses(1'b1, 4194303, 1'b0, 0);
        send_pulses(1'b0, 1234, 1'b1, 2000);
        send_pulses(1'b1, 505, 1'b1, 1);
        send_pulses(1'b1, 494, 1'b0, 77);
        send_pulses(1'b1, 0, 1'b1, 1500);
        send_pulses(1'b1, 22'h2AAAAA, 1'b1, 22'h155555);
        send_pulses(1'b1, 22'h155555, 1'b1, 22'h2AAAAA);
        send_random_items();
        drain_frames();

        send_idle_pct = 72;
        recv_idle_pct = 36;
        send_random_items();
        drain_frames();

        // No idling; a long output hold backs the block up into its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        send_random_items();
        drain_frames();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
